>>> src/atrs_pkg.sv
// shared types, constants and the arctangent table of the trs matrix builder
package atrs_pkg;

  // cordic depth as built, capped at the size of the arctangent table
  localparam int unsigned CordicStages = 16;
  localparam int unsigned TableLen     = 24;
  localparam int unsigned NumStages    = (CordicStages > TableLen) ? TableLen : CordicStages;
  localparam int unsigned StageIdxW    = $clog2(TableLen);

  // angle constants in q9.7 degrees
  localparam int FullTurn    = 46080;
  localparam int HalfTurn    = 23040;
  localparam int QuarterTurn = 11520;

  // 0.6072529350088813 in q2.30, the inverse cordic gain
  localparam int InvGainQ30 = 652032874;

  localparam int unsigned XyW   = 34;  // q2.30 with guard bits
  localparam int unsigned ZW    = 33;  // 2^-24 degree units
  localparam int unsigned TrigW = 17;  // q1.15 holding +1.0
  localparam int unsigned ProdW = 34;

  typedef struct packed {
    logic signed [16:0] angle_deg;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] shift_x;
    logic signed [15:0] shift_y;
  } req_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
  } res_t;

  // what travels from cell to cell
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic                  flip;
    logic signed [15:0]    scale_x;
    logic signed [15:0]    scale_y;
    logic signed [15:0]    shift_x;
    logic signed [15:0]    shift_y;
  } cordic_t;

  // atan(2^-i) in degrees, units of 2^-24 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_deg(input logic [StageIdxW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 33'sd754974720;
      5'd1:    v = 33'sd445687602;
      5'd2:    v = 33'sd235489088;
      5'd3:    v = 33'sd119537938;
      5'd4:    v = 33'sd60000934;
      5'd5:    v = 33'sd30029717;
      5'd6:    v = 33'sd15018523;
      5'd7:    v = 33'sd7509720;
      5'd8:    v = 33'sd3754917;
      5'd9:    v = 33'sd1877466;
      5'd10:   v = 33'sd938734;
      5'd11:   v = 33'sd469367;
      5'd12:   v = 33'sd234684;
      5'd13:   v = 33'sd117342;
      5'd14:   v = 33'sd58671;
      5'd15:   v = 33'sd29335;
      5'd16:   v = 33'sd14668;
      5'd17:   v = 33'sd7334;
      5'd18:   v = 33'sd3667;
      5'd19:   v = 33'sd1833;
      5'd20:   v = 33'sd917;
      5'd21:   v = 33'sd458;
      5'd22:   v = 33'sd229;
      5'd23:   v = 33'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/atrs_cell.sv
// one cordic rotation cell of the chain
module atrs_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic [atrs_pkg::StageIdxW-1:0]      stage_i,
  input  logic                                valid_i,
  input  atrs_pkg::cordic_t                   data_i,
  output logic                                valid_o,
  output atrs_pkg::cordic_t                   data_o
);

  logic signed [atrs_pkg::XyW-1:0] dx, dy;
  logic signed [atrs_pkg::ZW-1:0]  atan_v;
  logic                            valid_q;
  atrs_pkg::cordic_t               data_d, data_q;

  assign dx     = data_i.y >>> stage_i;
  assign dy     = data_i.x >>> stage_i;
  assign atan_v = atrs_pkg::atan_deg(stage_i);

  always_comb begin
    data_d = data_i;
    if (!data_i.z[atrs_pkg::ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - atan_v;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + atan_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/atrs_scale.sv
// sine and cosine rounding, the four products and the output register
module atrs_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  atrs_pkg::cordic_t data_i,
  output logic              valid_o,
  output atrs_pkg::res_t    res_o
);

  localparam int unsigned TW = atrs_pkg::TrigW;
  localparam int unsigned PW = atrs_pkg::ProdW;
  localparam int unsigned XW = atrs_pkg::XyW;

  logic signed [XW-1:0] cos_r, sin_r;
  logic signed [TW-1:0] cos_c, sin_c, cos_d, sin_d;
  logic signed [TW-1:0] cos_q, sin_q;
  logic signed [15:0]   sx_q, sy_q, tx_q, ty_q;
  logic                 trig_valid_q;

  logic signed [PW-1:0] p00_d, p01_d, p10_d, p11_d;
  logic signed [PW-1:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [15:0]   tx2_q, ty2_q;
  logic                 prod_valid_q;

  logic                 valid_q;
  atrs_pkg::res_t       res_d, res_q;

  // q2.30 to q1.15, round half up, clamp to plus or minus one
  function automatic logic signed [TW-1:0] to_q15(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    logic signed [TW-1:0] o;
    r = (v + XW'(16384)) >>> 15;
    if (r > XW'(32768)) begin
      o = TW'(32768);
    end else if (r < -XW'(32768)) begin
      o = -TW'(32768);
    end else begin
      o = TW'(r);
    end
    return o;
  endfunction

  // q9.23 to q8.8, round half up, saturate
  function automatic logic signed [15:0] to_q88(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic signed [15:0]   o;
    r = (p + PW'(16384)) >>> 15;
    if (r > PW'(32767)) begin
      o = 16'sh7fff;
    end else if (r < -PW'(32768)) begin
      o = 16'sh8000;
    end else begin
      o = 16'(r);
    end
    return o;
  endfunction

  assign cos_r = data_i.x;
  assign sin_r = data_i.y;
  assign cos_c = to_q15(cos_r);
  assign sin_c = to_q15(sin_r);
  assign cos_d = data_i.flip ? -cos_c : cos_c;
  assign sin_d = data_i.flip ? -sin_c : sin_c;

  always_comb begin
    p00_d = PW'(sx_q) * PW'(cos_q);
    p01_d = -(PW'(sy_q) * PW'(sin_q));
    p10_d = PW'(sx_q) * PW'(sin_q);
    p11_d = PW'(sy_q) * PW'(cos_q);
  end

  always_comb begin
    res_d.m00 = to_q88(p00_q);
    res_d.m01 = to_q88(p01_q);
    res_d.m02 = tx2_q;
    res_d.m10 = to_q88(p10_q);
    res_d.m11 = to_q88(p11_q);
    res_d.m12 = ty2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_valid_q <= 1'b0;
      prod_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else if (en_i) begin
      trig_valid_q <= valid_i;
      prod_valid_q <= trig_valid_q;
      valid_q      <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
      sx_q  <= data_i.scale_x;
      sy_q  <= data_i.scale_y;
      tx_q  <= data_i.shift_x;
      ty_q  <= data_i.shift_y;
      p00_q <= p00_d;
      p01_q <= p01_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
      tx2_q <= tx_q;
      ty2_q <= ty_q;
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> src/affine_trs_matrix_builder_core.sv
// top level of the 2d translate-rotate-scale matrix builder
// Builds the six variable entries of T*R*S from one request (angle in q9.7
// degrees, scales and shifts in q8.8): m00=sx*cos, m01=-sy*sin, m02=tx,
// m10=sx*sin, m11=sy*cos, m12=ty, all q8.8, rounded half up and saturated.
// One request is taken every cycle while the pipeline advances; a result
// passes in order through the angle folding register, the chain of cordic
// cells, and the trig rounding, product and output registers. The whole
// pipeline advances whenever the output register is empty or being drained,
// so ready falls only while a result waits at the output.
module affine_trs_matrix_builder_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  atrs_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output atrs_pkg::res_t out_res_o
);

  localparam int unsigned N    = atrs_pkg::NumStages;
  localparam int unsigned IdxW = atrs_pkg::StageIdxW;

  // pipeline advance: output empty or being taken
  logic advance;

  // angle folding into [-90, 90] degrees
  logic signed [17:0] a_ext, a_wrap, a_fold;
  logic               flip;
  atrs_pkg::cordic_t  entry_d;

  // chain links, index 0 is the folding register
  logic              valid_chain [N+1];
  atrs_pkg::cordic_t data_chain  [N+1];
  logic              valid0_q;
  atrs_pkg::cordic_t stage0_q;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  always_comb begin
    a_ext = 18'(in_req_i.angle_deg);
    // reduce modulo a full turn into [-180, 180)
    if (a_ext >= 18'(atrs_pkg::HalfTurn)) begin
      a_wrap = a_ext - 18'(atrs_pkg::FullTurn);
    end else if (a_ext < -18'(atrs_pkg::HalfTurn)) begin
      a_wrap = a_ext + 18'(atrs_pkg::FullTurn);
    end else begin
      a_wrap = a_ext;
    end
    // beyond a quarter turn: rotate by half a turn and negate sin and cos later
    flip = 1'b0;
    if (a_wrap > 18'(atrs_pkg::QuarterTurn)) begin
      a_fold = a_wrap - 18'(atrs_pkg::HalfTurn);
      flip   = 1'b1;
    end else if (a_wrap < -18'(atrs_pkg::QuarterTurn)) begin
      a_fold = a_wrap + 18'(atrs_pkg::HalfTurn);
      flip   = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
    // seed the cordic: x at the inverse gain, y at zero, z in 2^-24 degree
    entry_d.x       = atrs_pkg::XyW'(atrs_pkg::InvGainQ30);
    entry_d.y       = '0;
    entry_d.z       = atrs_pkg::ZW'(a_fold) <<< 17;
    entry_d.flip    = flip;
    entry_d.scale_x = in_req_i.scale_x;
    entry_d.scale_y = in_req_i.scale_y;
    entry_d.shift_x = in_req_i.shift_x;
    entry_d.shift_y = in_req_i.shift_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid0_q <= 1'b0;
    end else if (advance) begin
      valid0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stage0_q <= entry_d;
    end
  end

  assign valid_chain[0] = valid0_q;
  assign data_chain[0]  = stage0_q;

  // the cordic chain, one rotation per cell
  for (genvar g = 0; g < N; g++) begin : g_cell
    atrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .stage_i (IdxW'(g)),
      .valid_i (valid_chain[g]),
      .data_i  (data_chain[g]),
      .valid_o (valid_chain[g+1]),
      .data_o  (data_chain[g+1])
    );
  end

  // trig rounding, products and output register
  atrs_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (valid_chain[N]),
    .data_i  (data_chain[N]),
    .valid_o (out_valid_o),
    .res_o   (out_res_o)
  );

`ifndef SYNTH
  // an accepted request lands in the folding register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid0_q)
    else $error("accepted request did not enter the pipeline");

  // the folded angle stays within a quarter turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid0_q |-> (stage0_q.z <= (atrs_pkg::ZW'(atrs_pkg::QuarterTurn) <<< 17))
              && (stage0_q.z >= -(atrs_pkg::ZW'(atrs_pkg::QuarterTurn) <<< 17)))
    else $error("angle folding left the quarter turn");

  // a stall freezes the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid0_q) && $stable(valid_chain[N]) && $stable(stage0_q))
    else $error("pipeline moved during a stall");
`endif

endmodule

>>> dv/tb_affine_trs_matrix_builder_core.sv
// testbench of the translate-rotate-scale matrix builder core
`timescale 1ns / 100ps

module tb_affine_trs_matrix_builder_core;

  // run-away guard, far above the slowest legal run
  localparam int unsigned CycleLimit = 600000;
  // drain wait at the end: the depth of the pipeline plus a margin
  localparam int unsigned DrainCycles = atrs_pkg::NumStages + 16;
  localparam int unsigned LongHold = 400;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  atrs_pkg::req_t in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  atrs_pkg::res_t out_res_o;

  // atan(2^-i) in units of 2^-24 degree, rounded to nearest
  longint atan_q24 [0:23] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115
  };

  atrs_pkg::res_t pending_mats [$];   // matrices owed by the block, oldest first
  int unsigned    err_count = 0;
  int unsigned    cycle_count = 0;
  bit             gaps_on = 1'b1;     // random idling on both sides
  bit             hold_req = 1'b0;    // asks the receiver for one long hold-off
  int unsigned    stall_left;
  atrs_pkg::res_t want_mat;

  affine_trs_matrix_builder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // matrix predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // q8.8 times q1.15, rounded half up back to q8.8 and saturated to 16 bits
  function automatic logic signed [15:0] q88_product(input longint scale, input longint trig);
    longint p;
    p = clamp_range((scale * trig + 16384) >>> 15, -32768, 32767);
    return p[15:0];
  endfunction

  function automatic atrs_pkg::res_t predict_matrix(input atrs_pkg::req_t r);
    longint         ang, x, y, z, dx, dy, cosv, sinv, sx, sy;
    bit             flip;
    atrs_pkg::res_t m;
    ang  = r.angle_deg;
    sx   = r.scale_x;
    sy   = r.scale_y;
    flip = 1'b0;
    // one wrap by a full turn brings any 17-bit angle into [-180, 180)
    if (ang >= atrs_pkg::HalfTurn) ang -= atrs_pkg::FullTurn;
    else if (ang < -atrs_pkg::HalfTurn) ang += atrs_pkg::FullTurn;
    // fold the outer half-plane onto [-90, 90], negating sin and cos later
    if (ang > atrs_pkg::QuarterTurn) begin
      ang -= atrs_pkg::HalfTurn;
      flip = 1'b1;
    end else if (ang < -atrs_pkg::QuarterTurn) begin
      ang += atrs_pkg::HalfTurn;
      flip = 1'b1;
    end
    x = atrs_pkg::InvGainQ30;
    y = 0;
    z = ang * 131072;
    for (int i = 0; i < atrs_pkg::NumStages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_q24[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_q24[i];
      end
    end
    // q2.30 down to q1.15, +1.0 still representable
    cosv = clamp_range((x + 16384) >>> 15, -32768, 32768);
    sinv = clamp_range((y + 16384) >>> 15, -32768, 32768);
    if (flip) begin
      cosv = -cosv;
      sinv = -sinv;
    end
    m.m00 = q88_product(sx, cosv);
    m.m01 = q88_product(-sy, sinv);
    m.m02 = r.shift_x;
    m.m10 = q88_product(sx, sinv);
    m.m11 = q88_product(sy, cosv);
    m.m12 = r.shift_y;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one request and returns at the edge where it is taken; valid is
  // left high so a back-to-back request needs no second assignment
  task automatic send_req(input atrs_pkg::req_t r);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_mats.push_back(predict_matrix(r));
  endtask

  function automatic atrs_pkg::req_t make_req(input int a, input int sx, input int sy,
                                              input int tx, input int ty);
    atrs_pkg::req_t r;
    r.angle_deg = a[16:0];
    r.scale_x   = sx[15:0];
    r.scale_y   = sy[15:0];
    r.shift_x   = tx[15:0];
    r.shift_y   = ty[15:0];
    return r;
  endfunction

  // angles weighted towards the folding and wrap boundaries
  function automatic int rand_angle();
    int pivots [9] = '{0, 11520, -11520, 23040, -23040, 46080, -46080, 34560, -34560};
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 131071)) - 65536;
      1:       return int'($urandom_range(0, 92160)) - 46080;
      2:       return pivots[$urandom_range(0, 8)] + int'($urandom_range(0, 6)) - 3;
      default: return int'($urandom_range(0, 23040)) - 11520;
    endcase
  endfunction

  // q8.8 values: any pattern, near +-1.0, tiny, or at the limits
  function automatic int rand_q88();
    case ($urandom_range(0, 4))
      0, 1:    return int'($urandom_range(0, 65535)) - 32768;
      2:       return ($urandom_range(0, 1) ? 256 : -256) + int'($urandom_range(0, 64)) - 32;
      3:       return int'($urandom_range(0, 8)) - 4;
      default: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                           : -32768 + int'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic atrs_pkg::req_t rand_req();
    return make_req(rand_angle(), rand_q88(), rand_q88(), rand_q88(), rand_q88());
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    err_count++;
  endtask

  task automatic compare_entry(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, wanted %0d", name, $signed(got), $signed(want)));
  endtask

  // receiver: random stall bursts, or one long hold-off when asked
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        out_ready_i <= 1'b0;
        stall_left  = LongHold;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        stall_left  = $urandom_range(1, 8);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // every result taken is matched against the oldest owed matrix
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_mats.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want_mat = pending_mats.pop_front();
        compare_entry("m00", out_res_o.m00, want_mat.m00);
        compare_entry("m01", out_res_o.m01, want_mat.m01);
        compare_entry("m02", out_res_o.m02, want_mat.m02);
        compare_entry("m10", out_res_o.m10, want_mat.m10);
        compare_entry("m11", out_res_o.m11, want_mat.m11);
        compare_entry("m12", out_res_o.m12, want_mat.m12);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field limits, right angles, wrap and fold boundaries, saturation
  task automatic test_directed_corners();
    send_req(make_req(0, 256, 256, 0, 0));
    send_req(make_req(11520, 256, 256, 32767, -32768));        // +90 degrees
    send_req(make_req(-11520, -32768, -32768, -32768, 32767));  // -90 degrees
    send_req(make_req(23040, 32767, 32767, 4660, -4660));      // +180 wraps to -180
    send_req(make_req(-23040, -32768, 32767, 1, -1));          // -180 exactly
    send_req(make_req(46080, 256, -256, 0, 0));                // a full turn
    send_req(make_req(-46080, -256, 256, 0, 0));
    send_req(make_req(5760, 32767, 32767, 255, -256));         // 45 degrees
    send_req(make_req(65535, -32768, -32768, -1, 0));          // largest pattern
    send_req(make_req(-65536, 32767, -1, 0, -1));              // smallest pattern
    send_req(make_req(11521, 300, -300, 21845, -21846));       // just past +90
    send_req(make_req(-11521, -300, 300, -21846, 21845));      // just past -90
    send_req(make_req(23039, 512, 512, 0, 0));
    send_req(make_req(-23041, 512, 512, 0, 0));                // below -180
    send_req(make_req(11520, -32768, -32768, 0, 0));           // m01 saturates high
    send_req(make_req(0, -32768, 32767, 0, 0));                // +1.0 cosine at limits
    send_req(make_req(0, 0, 0, 0, 0));
    send_req(make_req(128, 1, 1, 0, 0));                       // one degree, tiny scales
    send_req(make_req(-128, -1, -1, 0, 0));
    send_req(make_req(34560, 32767, -32768, 32767, 32767));    // 270 degrees
    send_req(make_req(-34560, -32768, 32767, -32768, -32768));
    send_req(make_req(1, 32767, 32767, 0, 0));                 // smallest angle step
  endtask

  task automatic test_random_transforms(input int unsigned n);
    gaps_on = 1'b1;
    repeat (n) send_req(rand_req());
  endtask

  // output held off long enough for the pipeline to fill and stall the input
  task automatic test_output_backpressure(input int unsigned n);
    hold_req = 1'b1;
    repeat (n) send_req(rand_req());
  endtask

  // final stretch back to back on both sides
  task automatic test_streaming(input int unsigned n);
    gaps_on = 1'b0;
    repeat (n) send_req(rand_req());
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_random_transforms(1300);
    test_output_backpressure(80);
    test_streaming(570);

    in_valid_i <= 1'b0;
    while (pending_mats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
src/atrs_pkg.sv
src/atrs_cell.sv
src/atrs_scale.sv
src/affine_trs_matrix_builder_core.sv
dv/tb_affine_trs_matrix_builder_core.sv
